@@ hdl/tcpop_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpop_pkg
// Shared types and codes for the TCP option area parser.
// ----------------------------------------------------------------------------
package tcpop_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_KIND    = 4'd0;
  localparam logic [PhaseW-1:0] PH_MSS_LEN = 4'd1;
  localparam logic [PhaseW-1:0] PH_MSS_HI  = 4'd2;
  localparam logic [PhaseW-1:0] PH_MSS_LO  = 4'd3;
  localparam logic [PhaseW-1:0] PH_WS_LEN  = 4'd4;
  localparam logic [PhaseW-1:0] PH_WS_VAL  = 4'd5;
  localparam logic [PhaseW-1:0] PH_OPT_LEN = 4'd6;
  localparam logic [PhaseW-1:0] PH_SKIP    = 4'd7;
  localparam logic [PhaseW-1:0] PH_PAD     = 4'd8;
  localparam logic [PhaseW-1:0] PH_DRAIN   = 4'd9;

  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_MSS = 8'd2;
  localparam logic [7:0] KIND_WS  = 8'd3;

  localparam logic [7:0] MSS_LEN    = 8'd4;
  localparam logic [7:0] WS_LEN     = 8'd3;
  localparam logic [7:0] MIN_LEN    = 8'd2;
  localparam logic [7:0] WSCALE_MAX = 8'd14;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MSS_TRUNC = 3'd1,
    ERR_MSS_LEN   = 3'd2,
    ERR_WS_TRUNC  = 3'd3,
    ERR_WS_LEN    = 3'd4,
    ERR_NO_LEN    = 3'd5,
    ERR_OPT_TRUNC = 3'd6,
    ERR_LEN_SHORT = 3'd7
  } err_e;

  typedef struct packed {
    logic        mss_present;
    logic [15:0] mss_value;
    logic        wscale_present;
    logic [3:0]  wscale_shift;
    err_e        error_code;
    logic [7:0]  error_byte;
  } res_t;

endpackage

@@ hdl/tcpop_if.sv @@
// ----------------------------------------------------------------------------
// tcpop_if
// Request channels of the TCP option parser: option bytes in, summaries out.
// ----------------------------------------------------------------------------
interface tcpop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] option_byte;
  logic [5:0] bytes_left;

  modport source (output valid, output option_byte, output bytes_left, input ready);
  modport sink   (input valid, input option_byte, input bytes_left, output ready);
endinterface

interface tcpop_out_if;
  logic        valid;
  logic        ready;
  logic        mss_present;
  logic [15:0] mss_value;
  logic        wscale_present;
  logic [3:0]  wscale_shift;
  logic [2:0]  error_code;
  logic [7:0]  error_byte;

  modport source (output valid, output mss_present, output mss_value,
                  output wscale_present, output wscale_shift, output error_code,
                  output error_byte, input ready);
  modport sink   (input valid, input mss_present, input mss_value,
                  input wscale_present, input wscale_shift, input error_code,
                  input error_byte, output ready);
endinterface

@@ hdl/tcpop_core.sv @@
// ----------------------------------------------------------------------------
// tcpop_core
// Parse state and per-byte update; produces at most one summary per byte.
// ----------------------------------------------------------------------------
module tcpop_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [7:0]      byte_i,
  input  logic [5:0]      left_i,
  output logic            res_vld_o,
  output tcpop_pkg::res_t res_o
);

  logic [tcpop_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [7:0]  skip_q, skip_d;
  logic        mss_seen_q, mss_seen_d;
  logic [15:0] mss_q, mss_d;
  logic        ws_seen_q, ws_seen_d;
  logic [3:0]  ws_q, ws_d;
  logic [7:0]  kind_q, kind_d;

  tcpop_pkg::err_e err;
  logic [7:0] err_byte;
  logic       absorb;
  logic       clr;
  logic       last;
  logic [7:0] left_p1;

  assign last    = (left_i == 6'd1);
  assign left_p1 = {2'b00, left_i} + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    mss_seen_d = mss_seen_q;
    mss_d      = mss_q;
    ws_seen_d  = ws_seen_q;
    ws_d       = ws_q;
    kind_d     = kind_q;
    err        = tcpop_pkg::ERR_NONE;
    err_byte   = '0;
    absorb     = 1'b0;
    clr        = 1'b0;
    res_vld_o  = 1'b0;
    res_o      = '0;

    if (left_i == 6'd0) begin
      clr       = 1'b1;
      res_vld_o = 1'b1;
    end else begin
      unique case (phase_q)
        tcpop_pkg::PH_KIND: begin
          kind_d = byte_i;
          unique case (byte_i)
            tcpop_pkg::KIND_EOL: phase_d = tcpop_pkg::PH_PAD;
            tcpop_pkg::KIND_NOP: ;
            tcpop_pkg::KIND_MSS: begin
              if ({2'b00, left_i} < tcpop_pkg::MSS_LEN) begin
                err = tcpop_pkg::ERR_MSS_TRUNC;
                err_byte = byte_i;
              end else begin
                phase_d = tcpop_pkg::PH_MSS_LEN;
              end
            end
            tcpop_pkg::KIND_WS: begin
              if ({2'b00, left_i} < tcpop_pkg::WS_LEN) begin
                err = tcpop_pkg::ERR_WS_TRUNC;
                err_byte = byte_i;
              end else begin
                phase_d = tcpop_pkg::PH_WS_LEN;
              end
            end
            default: begin
              if ({2'b00, left_i} < tcpop_pkg::MIN_LEN) begin
                err = tcpop_pkg::ERR_NO_LEN;
                err_byte = byte_i;
              end else begin
                phase_d = tcpop_pkg::PH_OPT_LEN;
              end
            end
          endcase
        end
        tcpop_pkg::PH_MSS_LEN: begin
          if (byte_i != tcpop_pkg::MSS_LEN) begin
            err = tcpop_pkg::ERR_MSS_LEN;
            err_byte = byte_i;
          end else begin
            phase_d = tcpop_pkg::PH_MSS_HI;
          end
        end
        tcpop_pkg::PH_MSS_HI: begin
          skip_d  = byte_i;
          phase_d = tcpop_pkg::PH_MSS_LO;
        end
        tcpop_pkg::PH_MSS_LO: begin
          mss_d      = {skip_q, byte_i};
          mss_seen_d = 1'b1;
          skip_d     = '0;
          phase_d    = tcpop_pkg::PH_KIND;
        end
        tcpop_pkg::PH_WS_LEN: begin
          if (byte_i != tcpop_pkg::WS_LEN) begin
            err = tcpop_pkg::ERR_WS_LEN;
            err_byte = byte_i;
          end else begin
            phase_d = tcpop_pkg::PH_WS_VAL;
          end
        end
        tcpop_pkg::PH_WS_VAL: begin
          ws_d      = (byte_i > tcpop_pkg::WSCALE_MAX) ? tcpop_pkg::WSCALE_MAX[3:0]
                                                       : byte_i[3:0];
          ws_seen_d = 1'b1;
          phase_d   = tcpop_pkg::PH_KIND;
        end
        tcpop_pkg::PH_OPT_LEN: begin
          if (byte_i < tcpop_pkg::MIN_LEN) begin
            err = tcpop_pkg::ERR_LEN_SHORT;
            err_byte = byte_i;
          end else if (byte_i > left_p1) begin
            err = tcpop_pkg::ERR_OPT_TRUNC;
            err_byte = kind_q;
          end else begin
            skip_d  = byte_i - tcpop_pkg::MIN_LEN;
            phase_d = (skip_d != 8'd0) ? tcpop_pkg::PH_SKIP : tcpop_pkg::PH_KIND;
          end
        end
        tcpop_pkg::PH_SKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = tcpop_pkg::PH_KIND;
        end
        tcpop_pkg::PH_PAD: ;
        default: absorb = 1'b1;
      endcase

      if (absorb) begin
        clr = last;
      end else if (err != tcpop_pkg::ERR_NONE) begin
        res_vld_o        = 1'b1;
        res_o.error_code = err;
        res_o.error_byte = err_byte;
        clr              = 1'b1;
      end else if (last) begin
        res_vld_o = 1'b1;
        clr       = 1'b1;
        if (phase_d != tcpop_pkg::PH_KIND && phase_d != tcpop_pkg::PH_PAD) begin
          res_o.error_code = tcpop_pkg::ERR_OPT_TRUNC;
          res_o.error_byte = kind_d;
        end else begin
          res_o.mss_present    = mss_seen_d;
          res_o.mss_value      = mss_seen_d ? mss_d : 16'd0;
          res_o.wscale_present = ws_seen_d;
          res_o.wscale_shift   = ws_seen_d ? ws_d : 4'd0;
        end
      end
    end

    if (clr) begin
      phase_d    = tcpop_pkg::PH_KIND;
      skip_d     = '0;
      mss_seen_d = 1'b0;
      mss_d      = '0;
      ws_seen_d  = 1'b0;
      ws_d       = '0;
      kind_d     = '0;
    end
    // error mid-area: swallow the rest of the area
    if (!absorb && err != tcpop_pkg::ERR_NONE && !last) phase_d = tcpop_pkg::PH_DRAIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tcpop_pkg::PH_KIND;
      skip_q     <= '0;
      mss_seen_q <= 1'b0;
      mss_q      <= '0;
      ws_seen_q  <= 1'b0;
      ws_q       <= '0;
      kind_q     <= '0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      skip_q     <= skip_d;
      mss_seen_q <= mss_seen_d;
      mss_q      <= mss_d;
      ws_seen_q  <= ws_seen_d;
      ws_q       <= ws_d;
      kind_q     <= kind_d;
    end
  end

  a_err_no_opts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.error_code != tcpop_pkg::ERR_NONE |->
      !res_o.mss_present && !res_o.wscale_present && res_o.mss_value == 16'd0)
    else $error("option fields set on error summary");

  a_ok_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.error_code == tcpop_pkg::ERR_NONE |-> res_o.error_byte == 8'd0)
    else $error("error byte set without error");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last |=> phase_q == tcpop_pkg::PH_KIND && !mss_seen_q && !ws_seen_q)
    else $error("state not cleared at area end");

  a_ws_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_q <= tcpop_pkg::WSCALE_MAX[3:0])
    else $error("window scale above clamp");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && left_i == 6'd0 |-> res_vld_o && res_o == '0)
    else $error("empty area summary wrong");

endmodule

@@ hdl/tcp_option_parser_top.sv @@
// ----------------------------------------------------------------------------
// tcp_option_parser_top
// Streaming TCP option area parser with registered input and summary.
// ----------------------------------------------------------------------------
// Takes one option byte per cycle with no gaps needed while the summary
// register is empty or being read; each byte passes an input register, then
// the core's state update, then the summary register.
// A summary is produced for the last byte of an area (bytes_left 1), for an
// empty area (bytes_left 0), or at once on a malformed option; bytes after
// an error are consumed silently up to the end of the area.
module tcp_option_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcpop_in_if.sink     opt_i,
  tcpop_out_if.source  res_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic [5:0] in_left_q;
  logic       out_vld_q;
  tcpop_pkg::res_t out_q;

  logic            adv;
  logic            step_vld;
  tcpop_pkg::res_t step_res;

  assign adv         = in_vld_q && (!out_vld_q || res_o.ready);
  assign opt_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (opt_i.ready) begin
      in_vld_q <= opt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opt_i.ready && opt_i.valid) begin
      in_byte_q <= opt_i.option_byte;
      in_left_q <= opt_i.bytes_left;
    end
  end

  tcpop_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .byte_i    (in_byte_q),
    .left_i    (in_left_q),
    .res_vld_o (step_vld),
    .res_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && step_vld) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && step_vld) out_q <= step_res;
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.mss_present    = out_q.mss_present;
  assign res_o.mss_value      = out_q.mss_value;
  assign res_o.wscale_present = out_q.wscale_present;
  assign res_o.wscale_shift   = out_q.wscale_shift;
  assign res_o.error_code     = out_q.error_code;
  assign res_o.error_byte     = out_q.error_byte;

endmodule
